// ----- rtl/core/momd_pkg.sv -----
package momd_pkg;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_WINDOW_LENGTH   = 3'd0,
		REG_OUTLIERS_NEEDED = 3'd1,
		REG_MOVE_PCT        = 3'd2,
		REG_TOUCH_PCT       = 3'd3,
		REG_REPORT_ENABLE   = 3'd4
	} reg_index_t;

	// Sequencer states, one-hot
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_UPD  = 6'b000010,
		ST_MED  = 6'b000100,
		ST_MUL  = 6'b001000,
		ST_SCAN = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	localparam int unsigned WINDOW_RESET   = 5;
	localparam int unsigned OUTLIERS_RESET = 1;
	localparam int unsigned MOVE_RESET     = 50;
	localparam int unsigned TOUCH_RESET    = 20;

	localparam int unsigned OUTLIER_FLOOR  = 200;
	localparam int unsigned MEDIAN_SCALE   = 100;

	// Report: floor(x / 10) as (x * ceil(2^22 / 10)) >> 22, exact below 699050
	localparam int unsigned REPORT_SAT_IN  = 327680;
	localparam int unsigned REPORT_MAX     = 32767;
	localparam int unsigned RECIP10        = 419431;
	localparam int unsigned RECIP10_SHIFT  = 22;
	localparam int unsigned REPORT_IN_BITS = 19;
	localparam int unsigned REPORT_BITS    = 15;
	localparam int unsigned MEDIAN_BITS    = 24;

endpackage

// ----- rtl/core/momd_if.sv -----
interface momd_in_if #(parameter int W = 24);
	logic         valid;
	logic         ready;
	logic [W-1:0] jitter_sample;

	modport source (output valid, output jitter_sample, input ready);
	modport sink (input valid, input jitter_sample, output ready);
endinterface

interface momd_out_if;
	logic        valid;
	logic        ready;
	logic        decided;
	logic        move_detected;
	logic        touch_detected;
	logic [1:0]  event_code;
	logic        event_changed;
	logic [23:0] median_value;
	logic        report_valid;
	logic [14:0] report_value;

	modport source (output valid, output decided, output move_detected, output touch_detected,
		output event_code, output event_changed, output median_value, output report_valid,
		output report_value, input ready);
	modport sink (input valid, input decided, input move_detected, input touch_detected,
		input event_code, input event_changed, input median_value, input report_valid,
		input report_value, output ready);
endinterface

interface momd_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [7:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/momd_ram.sv -----
module momd_ram #(
	parameter int W     = 24,
	parameter int DEPTH = 75
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rdata_q;

	// Write one entry, read one entry registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/momd_cell.sv -----
module momd_cell #(
	parameter int W     = 24,
	parameter bit FIRST = 1'b0,
	parameter bit LAST  = 1'b0
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  logic [W-1:0] old_val,
	input  logic [W-1:0] new_val,
	input  logic [W-1:0] left_c,
	input  logic         left_lt,
	input  logic [W-1:0] right_val,
	output logic [W-1:0] val,
	output logic [W-1:0] c,
	output logic         c_lt
);

	logic [W-1:0] val_q;
	logic         after_del;
	logic         left_ok;
	logic [W-1:0] nxt;

	// Close the gap left by the outgoing value: cells at or past it take the right neighbor
	assign after_del = (val_q >= old_val);
	assign c         = after_del ? right_val : val_q;
	assign c_lt      = LAST ? 1'b0 : (c < new_val);

	// Open a slot for the incoming value after everything smaller
	assign left_ok = FIRST ? 1'b1 : left_lt;
	assign nxt     = c_lt ? c : (left_ok ? new_val : left_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else if (load) begin
			val_q <= nxt;
		end
	end

	assign val = val_q;

endmodule

// ----- rtl/core/median_outlier_motion_detector.sv -----
// Running-median outlier detector. Each jitter sample item replaces the oldest entry of a
// ring of RING_DEPTH samples (all zero after reset); a row of RING_DEPTH compare cells keeps
// the ring in sorted order, updated in the update state, so the median is read from the middle
// cells. Once window_length samples have arrived, the latest window_length samples are read
// back from the sample memory one per cycle and counted against the median for the move and
// touch thresholds, with window_length clamped to RING_DEPTH. The next item is taken as soon
// as the result sits in the output register, so an item is not taken before the previous
// result has been loaded there; a result that is not taken holds the block in its finishing
// state. Configuration is written through cfg at any time the block is idle.
module median_outlier_motion_detector
	import momd_pkg::*;
#(
	parameter int RING_DEPTH  = 75,
	parameter int SAMPLE_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	momd_in_if.sink     sample,
	momd_out_if.source  result,
	momd_cfg_if.sink    cfg
);

	localparam int PW    = $clog2(RING_DEPTH);
	localparam int FW    = $clog2(RING_DEPTH + 1);
	localparam int W     = SAMPLE_BITS;
	localparam int HALF  = RING_DEPTH / 2;
	localparam bit ODD   = (RING_DEPTH % 2) != 0;
	localparam int PRODW = W + 8;
	localparam int MEDW  = W + 7;
	localparam int RPW   = 2 * REPORT_IN_BITS;

	// Configuration registers
	logic [6:0] window_length_q;
	logic [6:0] outliers_needed_q;
	logic [7:0] move_pct_q;
	logic [7:0] touch_pct_q;
	logic       report_enable_q;

	state_t          state_q;
	logic [W-1:0]    sample_q;
	logic [7:0]      win_q;
	logic [PW-1:0]   wp_q;
	logic [FW-1:0]   fill_q;
	logic            decide_q;
	logic [PW-1:0]   scan_addr_q;
	logic [7:0]      issue_cnt_q;
	logic            rv_s1;
	logic            valid_s2;
	logic            big_s2;
	logic [PRODW-1:0] prod_m_s2;
	logic [PRODW-1:0] prod_t_s2;
	logic [7:0]      mv_cnt_q;
	logic [7:0]      tc_cnt_q;
	logic [W-1:0]    med_q;
	logic [MEDW-1:0] med100_q;
	logic [RPW-1:0]  rep_prod_q;
	logic            rep_sat_q;
	logic [1:0]      last_event_q;

	logic            out_valid_q;
	logic            decided_q;
	logic            move_q;
	logic            touch_q;
	logic [1:0]      code_q;
	logic            changed_q;
	logic [MEDIAN_BITS-1:0] median_out_q;
	logic            rep_valid_q;
	logic [REPORT_BITS-1:0] rep_value_q;

	logic            accept;
	logic [W-1:0]    s_in;
	logic [7:0]      win_clamped;
	logic [PW-1:0]   raddr;
	logic [W-1:0]    rdata;
	logic [W-1:0]    old_val;
	logic            chain_load;
	logic [PW-1:0]   wp_nxt;
	logic [FW-1:0]   fill_nxt;
	logic [W:0]      mid_sum;
	logic [W-1:0]    median_w;
	logic            scan_issue;
	logic            scan_idle;
	logic            out_free;
	logic            mflag;
	logic            tflag;
	logic [1:0]      code_w;
	logic [32:0]     s_ext;
	logic [W+MEDIAN_BITS-1:0] med_ext;

	logic [W-1:0] vals  [RING_DEPTH];
	logic [W-1:0] c_arr [RING_DEPTH];
	logic         lt_arr[RING_DEPTH];

	assign accept = sample.valid && sample.ready;
	assign s_in   = sample.jitter_sample;
	assign sample.ready = (state_q == ST_IDLE);
	assign cfg.ready    = 1'b1;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q   <= 7'(WINDOW_RESET);
			outliers_needed_q <= 7'(OUTLIERS_RESET);
			move_pct_q        <= 8'(MOVE_RESET);
			touch_pct_q       <= 8'(TOUCH_RESET);
			report_enable_q   <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_WINDOW_LENGTH:   window_length_q   <= cfg.data[6:0];
				REG_OUTLIERS_NEEDED: outliers_needed_q <= cfg.data[6:0];
				REG_MOVE_PCT:        move_pct_q        <= cfg.data;
				REG_TOUCH_PCT:       touch_pct_q       <= cfg.data;
				REG_REPORT_ENABLE:   report_enable_q   <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign win_clamped = ({1'b0, window_length_q} > 8'(RING_DEPTH)) ?
		8'(RING_DEPTH) : {1'b0, window_length_q};

	// Sample memory: ring written at the write pointer, scanned newest first
	assign raddr = (state_q == ST_SCAN) ? scan_addr_q : wp_q;

	momd_ram #(.W(W), .DEPTH(RING_DEPTH)) u_ring (
		.clk   (clk),
		.we    (state_q == ST_UPD),
		.waddr (wp_q),
		.wdata (sample_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Until the ring has filled, the outgoing value is taken as zero, the reset value of the cells
	assign old_val    = (fill_q < FW'(RING_DEPTH)) ? '0 : rdata;
	assign chain_load = (state_q == ST_UPD);

	// Row of sorted cells
	for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
		logic [W-1:0] left_c;
		logic         left_lt;
		logic [W-1:0] right_val;

		if (i == 0) begin : g_first
			assign left_c  = '0;
			assign left_lt = 1'b1;
		end else begin : g_mid
			assign left_c  = c_arr[i-1];
			assign left_lt = lt_arr[i-1];
		end
		if (i == RING_DEPTH - 1) begin : g_last
			assign right_val = '0;
		end else begin : g_inner
			assign right_val = vals[i+1];
		end

		momd_cell #(.W(W), .FIRST(i == 0), .LAST(i == RING_DEPTH - 1)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.load      (chain_load),
			.old_val   (old_val),
			.new_val   (sample_q),
			.left_c    (left_c),
			.left_lt   (left_lt),
			.right_val (right_val),
			.val       (vals[i]),
			.c         (c_arr[i]),
			.c_lt      (lt_arr[i])
		);
	end

	// Median of the middle cell, or floor mean of the two middle cells
	assign mid_sum  = {1'b0, vals[HALF-1]} + {1'b0, vals[HALF]};
	assign median_w = ODD ? vals[HALF] : mid_sum[W:1];

	assign wp_nxt   = (wp_q == PW'(RING_DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign fill_nxt = (fill_q == FW'(RING_DEPTH)) ? fill_q : fill_q + 1'b1;

	assign scan_issue = (state_q == ST_SCAN) && (issue_cnt_q != 8'd0);
	assign scan_idle  = (issue_cnt_q == 8'd0) && !rv_s1 && !valid_s2;
	assign out_free   = !out_valid_q || result.ready;

	assign s_ext   = 33'(sample_q);
	assign med_ext = (W + MEDIAN_BITS)'(med_q);

	assign mflag  = (mv_cnt_q >= {1'b0, outliers_needed_q});
	assign tflag  = (tc_cnt_q >= {1'b0, outliers_needed_q});
	assign code_w = {mflag, tflag};

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			wp_q         <= '0;
			fill_q       <= '0;
			decide_q     <= 1'b0;
			issue_cnt_q  <= '0;
			last_event_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					wp_q        <= wp_nxt;
					fill_q      <= fill_nxt;
					issue_cnt_q <= (9'(fill_nxt) >= 9'(win_q)) ? win_q : 8'd0;
					decide_q    <= (9'(fill_nxt) >= 9'(win_q));
					state_q     <= (9'(fill_nxt) >= 9'(win_q)) ? ST_MED : ST_DONE;
				end
				ST_MED: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_SCAN;
				ST_SCAN: begin
					if (scan_issue) begin
						issue_cnt_q <= issue_cnt_q - 1'b1;
					end
					if (scan_idle) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						if (decide_q) begin
							last_event_q <= code_w;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item capture, median, report scaling
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= s_in;
			win_q    <= win_clamped;
		end
		if (state_q == ST_UPD) begin
			scan_addr_q <= wp_q;
			rep_sat_q   <= (s_ext >= 33'(REPORT_SAT_IN));
			rep_prod_q  <= RPW'(s_ext[REPORT_IN_BITS-1:0]) * RPW'(RECIP10);
		end
		if (state_q == ST_MED) begin
			med_q <= median_w;
		end
		if (state_q == ST_MUL) begin
			med100_q <= MEDW'(med_q) * MEDW'(MEDIAN_SCALE);
		end
		if (scan_issue) begin
			scan_addr_q <= (scan_addr_q == '0) ? PW'(RING_DEPTH - 1) : scan_addr_q - 1'b1;
		end
	end

	// Scan pipeline: read, multiply, compare and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1    <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			rv_s1    <= scan_issue;
			valid_s2 <= rv_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rv_s1) begin
			big_s2    <= (33'(rdata) > 33'(OUTLIER_FLOOR));
			prod_m_s2 <= PRODW'(rdata) * PRODW'(move_pct_q);
			prod_t_s2 <= PRODW'(rdata) * PRODW'(touch_pct_q);
		end
		if (state_q == ST_UPD) begin
			mv_cnt_q <= '0;
			tc_cnt_q <= '0;
		end else if (valid_s2 && big_s2) begin
			if (prod_m_s2 > PRODW'(med100_q)) begin
				mv_cnt_q <= mv_cnt_q + 1'b1;
			end
			if (prod_t_s2 > PRODW'(med100_q)) begin
				tc_cnt_q <= tc_cnt_q + 1'b1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			decided_q    <= decide_q;
			move_q       <= decide_q && mflag;
			touch_q      <= decide_q && tflag;
			code_q       <= decide_q ? code_w : 2'b00;
			changed_q    <= decide_q && (code_w != last_event_q);
			median_out_q <= decide_q ? med_ext[MEDIAN_BITS-1:0] : '0;
			rep_valid_q  <= decide_q && report_enable_q;
			if (decide_q && report_enable_q) begin
				rep_value_q <= rep_sat_q ? REPORT_BITS'(REPORT_MAX) :
					rep_prod_q[RECIP10_SHIFT +: REPORT_BITS];
			end else begin
				rep_value_q <= '0;
			end
		end
	end

	assign result.valid          = out_valid_q;
	assign result.decided        = decided_q;
	assign result.move_detected  = move_q;
	assign result.touch_detected = touch_q;
	assign result.event_code     = code_q;
	assign result.event_changed  = changed_q;
	assign result.median_value   = median_out_q;
	assign result.report_valid   = rep_valid_q;
	assign result.report_value   = rep_value_q;

`ifndef ASSERT_OFF
	logic chain_sorted;

	always_comb begin
		chain_sorted = 1'b1;
		for (int k = 0; k < RING_DEPTH - 1; k++) begin
			if (vals[k] > vals[k+1]) begin
				chain_sorted = 1'b0;
			end
		end
	end

	a_chain_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		chain_sorted)
		else $error("sorted cell row out of order");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(RING_DEPTH))
		else $error("fill count beyond ring depth");

	a_scan_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		sample.ready |-> (issue_cnt_q == 8'd0 && !rv_s1 && !valid_s2))
		else $error("scan still running while taking an item");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result loaded outside the finishing state");
`endif

endmodule

// ----- sim/tb_median_outlier_motion_detector.sv -----
`timescale 1ns / 1ps

module tb_median_outlier_motion_detector
	import momd_pkg::*;
;

	localparam int DEPTH           = 75;
	localparam int SBITS           = 24;
	localparam int JITTER_FLOOR    = 200;
	localparam int MEDIAN_GAIN     = 100;
	localparam int REPORT_CEIL     = 32767;
	localparam int RANDOM_PHASES   = 12;
	localparam int ITEMS_PER_PHASE = 92;
	localparam int GAP_PCT         = 46;
	localparam int BOTH_GAP_PCT    = 22;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int DRAIN_CYCLES    = 100;
	localparam int MAX_REPORTS     = 10;

	typedef struct packed {
		logic        decided;
		logic        move_det;
		logic        touch_det;
		logic [1:0]  code;
		logic        changed;
		logic [23:0] median;
		logic        rep_valid;
		logic [14:0] rep_value;
	} motion_verdict_t;

	typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		reg_index_t  idx;
		logic [7:0]  data;
		logic [23:0] jitter;
		bit          expect_zero;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	momd_in_if #(.W(SBITS)) sample_bus();
	momd_out_if             result_bus();
	momd_cfg_if             cfg_bus();

	median_outlier_motion_detector #(
		.RING_DEPTH (DEPTH),
		.SAMPLE_BITS(SBITS)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.sample(sample_bus),
		.result(result_bus),
		.cfg   (cfg_bus)
	);

	always #5 clk = ~clk;

	// Detector model state and register copy
	logic [23:0]     ring_mem [DEPTH];
	logic [23:0]     sorted_mem [DEPTH];
	int unsigned     wr_ptr;
	int unsigned     fill_cnt;
	logic [1:0]      prev_code;
	logic [6:0]      win_len;
	logic [6:0]      outlier_lim;
	logic [7:0]      move_pct;
	logic [7:0]      touch_pct;
	logic            rep_en;

	motion_verdict_t verdict_queue [$];
	stim_row_t       stim_plan [$];
	int              mismatch_count = 0;
	int              idle_pct = 0;
	int              stall_pct = 0;
	int              quiet_cycles = 0;

	// Advance the model by one sample and return the verdict it causes
	function automatic motion_verdict_t predict_verdict(input logic [23:0] s);
		int unsigned     pos;
		int unsigned     win;
		int unsigned     moves;
		int unsigned     touches;
		int unsigned     slot;
		bit              found;
		logic [23:0]     tmp;
		logic [23:0]     med;
		logic [23:0]     v;
		logic [39:0]     med_scaled;
		motion_verdict_t res;
		pos = 0;
		found = 1'b0;
		// Replace the oldest ring entry in the sorted copy, then restore order
		for (int k = 0; k < DEPTH; k++) begin
			if (!found && sorted_mem[k] == ring_mem[wr_ptr]) begin
				pos = k;
				found = 1'b1;
			end
		end
		sorted_mem[pos] = s;
		while (pos > 0 && sorted_mem[pos-1] > sorted_mem[pos]) begin
			tmp = sorted_mem[pos-1];
			sorted_mem[pos-1] = sorted_mem[pos];
			sorted_mem[pos] = tmp;
			pos--;
		end
		while (pos + 1 < DEPTH && sorted_mem[pos+1] < sorted_mem[pos]) begin
			tmp = sorted_mem[pos+1];
			sorted_mem[pos+1] = sorted_mem[pos];
			sorted_mem[pos] = tmp;
			pos++;
		end
		ring_mem[wr_ptr] = s;
		wr_ptr = (wr_ptr + 1 >= DEPTH) ? 0 : wr_ptr + 1;
		if (fill_cnt < DEPTH)
			fill_cnt++;
		win = (win_len > DEPTH) ? DEPTH : win_len;
		res = '0;
		// Hold off the decision until the window has filled
		if (fill_cnt < win)
			return res;
		if (DEPTH % 2 != 0)
			med = sorted_mem[DEPTH/2];
		else
			med = 24'((25'(sorted_mem[DEPTH/2-1]) + 25'(sorted_mem[DEPTH/2])) >> 1);
		med_scaled = 40'(med) * 40'(MEDIAN_GAIN);
		moves = 0;
		touches = 0;
		// Count outliers among the latest window samples, newest first
		for (int unsigned k = 0; k < win; k++) begin
			slot = (wr_ptr + DEPTH - 1 - k) % DEPTH;
			v = ring_mem[slot];
			if (v > JITTER_FLOOR) begin
				if (40'(v) * 40'(move_pct) > med_scaled)
					moves++;
				if (40'(v) * 40'(touch_pct) > med_scaled)
					touches++;
			end
		end
		res.decided = 1'b1;
		res.move_det = (moves >= outlier_lim);
		res.touch_det = (touches >= outlier_lim);
		res.code = {res.move_det, res.touch_det};
		res.changed = (res.code != prev_code);
		res.median = med;
		if (rep_en) begin
			res.rep_valid = 1'b1;
			res.rep_value = (s / 10 > REPORT_CEIL) ? 15'(REPORT_CEIL) : 15'(s / 10);
		end
		prev_code = res.code;
		return res;
	endfunction

	function automatic void plan_item(input logic [23:0] s, input bit expect_zero);
		stim_row_t row;
		row.kind = ROW_SAMPLE;
		row.idx = REG_WINDOW_LENGTH;
		row.data = '0;
		row.jitter = s;
		row.expect_zero = expect_zero;
		stim_plan.push_back(row);
	endfunction

	function automatic void plan_write(input reg_index_t idx, input logic [7:0] d);
		stim_row_t row;
		row.kind = ROW_WRITE;
		row.idx = idx;
		row.data = d;
		row.jitter = '0;
		row.expect_zero = 1'b0;
		stim_plan.push_back(row);
	endfunction

	// Offer one jitter item, then queue its expected verdict once accepted
	task automatic send_jitter(input logic [23:0] s, input bit expect_zero);
		motion_verdict_t pred;
		cfg_bus.valid <= 1'b0;
		while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			sample_bus.valid <= 1'b0;
			@(posedge clk);
		end
		sample_bus.valid <= 1'b1;
		sample_bus.jitter_sample <= s;
		do @(posedge clk); while (!(sample_bus.valid && sample_bus.ready));
		pred = predict_verdict(s);
		verdict_queue.push_back(expect_zero ? motion_verdict_t'('0) : pred);
	endtask

	// Write one register once every pending verdict has drained
	task automatic write_reg(input reg_index_t idx, input logic [7:0] d);
		sample_bus.valid <= 1'b0;
		while (verdict_queue.size() != 0)
			@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= d;
		do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
		case (idx)
			REG_WINDOW_LENGTH:   win_len = d[6:0];
			REG_OUTLIERS_NEEDED: outlier_lim = d[6:0];
			REG_MOVE_PCT:        move_pct = d;
			REG_TOUCH_PCT:       touch_pct = d;
			REG_REPORT_ENABLE:   rep_en = d[0];
			default: ;
		endcase
	endtask

	// Result side: check each accepted verdict, then drive ready for the next edge
	initial begin
		motion_verdict_t got;
		motion_verdict_t want;
		result_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (result_bus.valid && result_bus.ready) begin
				got = {result_bus.decided, result_bus.move_detected, result_bus.touch_detected,
					result_bus.event_code, result_bus.event_changed, result_bus.median_value,
					result_bus.report_valid, result_bus.report_value};
				if (verdict_queue.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("unexpected verdict with nothing pending at %0t", $time);
				end else begin
					want = verdict_queue.pop_front();
					if (got !== want) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS) begin
							$write("verdict mismatch at %0t: decided %0b/%0b move %0b/%0b ",
								$time, want.decided, got.decided, want.move_det,
								got.move_det);
							$write("touch %0b/%0b code %0d/%0d changed %0b/%0b ",
								want.touch_det, got.touch_det, want.code, got.code,
								want.changed, got.changed);
							$display({"median %0d/%0d rep_valid %0b/%0b rep_value %0d/%0d",
								" (expected/actual)"}, want.median, got.median,
								want.rep_valid, got.rep_valid, want.rep_value,
								got.rep_value);
						end
					end
				end
			end
			result_bus.ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Drop the run when no channel moves an item for too long
	always @(posedge clk) begin
		if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready) ||
			(cfg_bus.valid && cfg_bus.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("median_outlier_motion_detector verification failed");
				$finish;
			end
		end
	end

	initial begin
		logic [23:0] base;
		logic [23:0] s;
		int          pick;
		arst_n = 1'b0;
		sample_bus.valid = 1'b0;
		sample_bus.jitter_sample = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = REG_WINDOW_LENGTH;
		cfg_bus.data = '0;
		// Model after reset: cleared ring, default registers
		for (int k = 0; k < DEPTH; k++) begin
			ring_mem[k] = '0;
			sorted_mem[k] = '0;
		end
		wr_ptr = 0;
		fill_cnt = 0;
		prev_code = '0;
		win_len = 7'd5;
		outlier_lim = 7'd1;
		move_pct = 8'd50;
		touch_pct = 8'd20;
		rep_en = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: window not yet filled gives an all-zero verdict
		plan_item(24'd0, 1'b1);
		plan_item(24'hFFFFFF, 1'b1);
		plan_item(24'd200, 1'b1);
		plan_item(24'd201, 1'b1);
		// First decision with the report still off
		plan_item(24'd202, 1'b0);
		// Report on: saturation edge and small values
		plan_write(REG_REPORT_ENABLE, 8'd1);
		plan_item(24'hFFFFFF, 1'b0);
		plan_item(24'd327679, 1'b0);
		plan_item(24'd327680, 1'b0);
		plan_item(24'd9, 1'b0);
		plan_item(24'd10, 1'b0);
		// Zero outlier limit sets both flags
		plan_write(REG_OUTLIERS_NEEDED, 8'd0);
		plan_item(24'd0, 1'b0);
		// Zero window decides at once with empty counts
		plan_write(REG_WINDOW_LENGTH, 8'd0);
		plan_write(REG_OUTLIERS_NEEDED, 8'd1);
		plan_item(24'd5000, 1'b0);
		// Window beyond the ring depth is clamped
		plan_write(REG_WINDOW_LENGTH, 8'd127);
		plan_item(24'd7000, 1'b0);
		// Sensitivity extremes
		plan_write(REG_WINDOW_LENGTH, 8'd1);
		plan_write(REG_MOVE_PCT, 8'd255);
		plan_write(REG_TOUCH_PCT, 8'd0);
		plan_item(24'd3000000, 1'b0);
		plan_write(REG_MOVE_PCT, 8'd0);
		plan_write(REG_TOUCH_PCT, 8'd255);
		plan_item(24'd3000000, 1'b0);
		plan_write(REG_WINDOW_LENGTH, 8'd75);
		plan_write(REG_OUTLIERS_NEEDED, 8'd75);
		plan_item(24'd100, 1'b0);
		// Upper data bits are dropped by the register widths
		plan_write(REG_REPORT_ENABLE, 8'hFE);
		plan_write(REG_WINDOW_LENGTH, 8'h85);
		plan_item(24'd1000, 1'b0);
		plan_item(24'd1000000, 1'b0);
		plan_item(24'd201, 1'b0);
		plan_item(24'd0, 1'b0);

		foreach (stim_plan[r]) begin
			if (stim_plan[r].kind == ROW_WRITE)
				write_reg(stim_plan[r].idx, stim_plan[r].data);
			else
				send_jitter(stim_plan[r].jitter, stim_plan[r].expect_zero);
		end

		// Random phases: new settings, idling pattern and baseline per phase
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = GAP_PCT;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = GAP_PCT;
				end
				default: begin
					idle_pct = BOTH_GAP_PCT;
					stall_pct = BOTH_GAP_PCT;
				end
			endcase
			case (p)
				0: begin
					write_reg(REG_WINDOW_LENGTH, 8'h7F);
					write_reg(REG_OUTLIERS_NEEDED, 8'd75);
					write_reg(REG_MOVE_PCT, 8'd255);
					write_reg(REG_TOUCH_PCT, 8'd0);
					write_reg(REG_REPORT_ENABLE, 8'd1);
				end
				1: begin
					write_reg(REG_WINDOW_LENGTH, 8'd1);
					write_reg(REG_OUTLIERS_NEEDED, 8'd0);
					write_reg(REG_MOVE_PCT, 8'd0);
					write_reg(REG_TOUCH_PCT, 8'd255);
					write_reg(REG_REPORT_ENABLE, 8'd0);
				end
				2: begin
					write_reg(REG_WINDOW_LENGTH, 8'd75);
					write_reg(REG_OUTLIERS_NEEDED, 8'd1);
					write_reg(REG_MOVE_PCT, 8'd50);
					write_reg(REG_TOUCH_PCT, 8'd20);
					write_reg(REG_REPORT_ENABLE, 8'hFF);
				end
				3: begin
					write_reg(REG_WINDOW_LENGTH, 8'd0);
					write_reg(REG_OUTLIERS_NEEDED, 8'd75);
					write_reg(REG_MOVE_PCT, 8'd100);
					write_reg(REG_TOUCH_PCT, 8'd100);
					write_reg(REG_REPORT_ENABLE, 8'd1);
				end
				default: begin
					pick = $urandom_range(0, 2);
					write_reg(REG_WINDOW_LENGTH, (pick == 0) ? 8'($urandom_range(0, 255)) :
						(pick == 1) ? 8'($urandom_range(1, 12)) : 8'd75);
					pick = $urandom_range(0, 2);
					write_reg(REG_OUTLIERS_NEEDED, (pick == 0) ? 8'($urandom_range(0, 255)) :
						8'($urandom_range(0, 8)));
					write_reg(REG_MOVE_PCT, 8'($urandom_range(0, 255)));
					write_reg(REG_TOUCH_PCT, 8'($urandom_range(0, 255)));
					write_reg(REG_REPORT_ENABLE, 8'($urandom_range(0, 255)));
				end
			endcase
			base = 24'($urandom_range(300, 20000));
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Mostly baseline jitter with spikes, plus floor, zero and full-range noise
				pick = $urandom_range(0, 99);
				if (pick < 55)
					s = base + 24'($urandom_range(0, base / 4));
				else if (pick < 80)
					s = 24'(base * $urandom_range(2, 40));
				else if (pick < 88)
					s = 24'($urandom_range(150, 250));
				else if (pick < 93)
					s = '0;
				else if (pick < 97)
					s = 24'($urandom);
				else
					s = 24'hFFFFFF;
				send_jitter(s, 1'b0);
			end
		end

		// Drain outstanding verdicts, then watch for strays
		sample_bus.valid <= 1'b0;
		cfg_bus.valid <= 1'b0;
		while (verdict_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (verdict_queue.size() != 0)
			mismatch_count++;
		if (mismatch_count == 0)
			$display("median_outlier_motion_detector verification clean");
		else
			$display("median_outlier_motion_detector verification failed");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/momd_pkg.sv
rtl/core/momd_if.sv
rtl/core/momd_ram.sv
rtl/core/momd_cell.sv
rtl/core/median_outlier_motion_detector.sv
sim/tb_median_outlier_motion_detector.sv
